/* design/mlpd_pkg.sv */
// shared types and constants for the masked length-prefix deframer
// no dependencies; imported by the header parser, the top level and the checker
`default_nettype none

package mlpd_pkg;

   localparam int HEADER_BYTES  = 8;
   localparam int BYTE_W        = 8;
   localparam int WORD_W        = 32;
   localparam int LENGTH_W      = 31;
   // bytes held before the closing header byte arrives
   localparam int HEADER_KEEP_W = (HEADER_BYTES - 1) * BYTE_W;
   localparam int HEADER_CNT_W  = $clog2(HEADER_BYTES);
   localparam logic [HEADER_CNT_W-1:0] HEADER_LAST_COUNT = HEADER_CNT_W'(HEADER_BYTES - 1);

   // configuration map
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_XOR_KEY_ADDR = 2'd0;

   // result kinds
   localparam logic ITEM_HEADER  = 1'b0;
   localparam logic ITEM_PAYLOAD = 1'b1;

   typedef struct packed {
      logic                item_type;
      logic [WORD_W-1:0]   pack_id;
      logic [LENGTH_W-1:0] frame_length;
      logic [BYTE_W-1:0]   payload_byte;
      logic                last;
      logic                length_error;
   } mlpd_result_type;

endpackage

`default_nettype wire

/* design/mlpd_parse.sv */
// header assembly and payload counting for the deframer
// depends on mlpd_pkg; one accepted byte in, at most one result out in the same cycle
`default_nettype none

module mlpd_parse (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_accept,
   input  wire logic [mlpd_pkg::BYTE_W-1:0]     in_byte,
   input  wire logic [mlpd_pkg::WORD_W-1:0]     xor_key,
   output logic                                 res_valid,
   output mlpd_pkg::mlpd_result_type            res_item
);
   import mlpd_pkg::*;

   logic [HEADER_KEEP_W-1:0] header_shift_ff, header_shift_in;
   logic [HEADER_CNT_W-1:0]  header_count_ff, header_count_in;
   logic                     in_payload_ff,   in_payload_in;
   logic [LENGTH_W-1:0]      bytes_left_ff,   bytes_left_in;
   logic [WORD_W-1:0]        held_id_ff,      held_id_in;

   always_comb begin
      logic [WORD_W-1:0]   raw_id;
      logic [WORD_W-1:0]   raw_len;
      logic [WORD_W-1:0]   id_word;
      logic [WORD_W-1:0]   len_word;
      logic [LENGTH_W-1:0] left_next;

      raw_id    = header_shift_ff[HEADER_KEEP_W-1 -: WORD_W];
      raw_len   = {header_shift_ff[WORD_W-BYTE_W-1:0], in_byte};
      id_word   = raw_id ^ xor_key;
      len_word  = raw_len ^ xor_key;
      left_next = bytes_left_ff - LENGTH_W'(1);

      header_shift_in = header_shift_ff;
      header_count_in = header_count_ff;
      in_payload_in   = in_payload_ff;
      bytes_left_in   = bytes_left_ff;
      held_id_in      = held_id_ff;
      res_valid       = 1'b0;
      res_item        = '0;

      if (in_accept) begin
         if (in_payload_ff) begin
            bytes_left_in         = left_next;
            in_payload_in         = (left_next != '0);
            res_valid             = 1'b1;
            res_item.item_type    = ITEM_PAYLOAD;
            res_item.pack_id      = held_id_ff;
            res_item.payload_byte = in_byte;
            res_item.last         = (left_next == '0);
         end else if (header_count_ff != HEADER_LAST_COUNT) begin
            header_shift_in = {header_shift_ff[HEADER_KEEP_W-BYTE_W-1:0], in_byte};
            header_count_in = header_count_ff + HEADER_CNT_W'(1);
         end else begin
            // closing header byte
            header_shift_in    = '0;
            header_count_in    = '0;
            held_id_in         = id_word;
            res_valid          = 1'b1;
            res_item.item_type = ITEM_HEADER;
            res_item.pack_id   = id_word;
            if (len_word[WORD_W-1]) begin
               // sign bit set: flag and treat as empty frame
               bytes_left_in         = '0;
               res_item.last         = 1'b1;
               res_item.length_error = 1'b1;
            end else if (len_word == '0) begin
               bytes_left_in = '0;
               res_item.last = 1'b1;
            end else begin
               bytes_left_in         = len_word[LENGTH_W-1:0];
               in_payload_in         = 1'b1;
               res_item.frame_length = len_word[LENGTH_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_shift_ff <= '0;
         header_count_ff <= '0;
         in_payload_ff   <= 1'b0;
         bytes_left_ff   <= '0;
         held_id_ff      <= '0;
      end else begin
         header_shift_ff <= header_shift_in;
         header_count_ff <= header_count_in;
         in_payload_ff   <= in_payload_in;
         bytes_left_ff   <= bytes_left_in;
         held_id_ff      <= held_id_in;
      end
   end

endmodule

`default_nettype wire

/* design/masked_length_prefix_deframer.sv */
// top level of the masked length-prefix deframer: csr port, parser, output skid stage
// depends on mlpd_pkg and mlpd_parse
// usage
//   req channel: one received stream byte per item (req_data_byte), valid/ready
//   rsp channel: one result per header and per payload byte, valid/ready
//     header result: item_type 0, unmasked pack_id and frame_length, last set
//     for an empty frame, length_error set when the unmasked length has bit 31
//     set (then frame_length is 0 and the frame counts as empty)
//     payload result: item_type 1, payload_byte, pack_id of the frame, last on
//     the final byte
//   the first seven header bytes of each frame produce no result
//   csr port: xor key at byte address 0, xored onto both header words and
//     sampled when the closing header byte is accepted
// timing
//   one item per cycle sustained while rsp_ready stays high; each result is
//   registered and is presented from the output register
//   a two-entry output stage (output register plus skid register) lets a new
//   item in while a finished result waits; req_ready drops only when both hold
// reset: synchronous, active high; parser expects a fresh header, key clears
//   to 0, no result pending
`default_nettype none

module masked_length_prefix_deframer (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // byte stream in
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [mlpd_pkg::BYTE_W-1:0]        req_data_byte,
   // results out
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_item_type,
   output logic [mlpd_pkg::WORD_W-1:0]             rsp_pack_id,
   output logic [mlpd_pkg::LENGTH_W-1:0]           rsp_frame_length,
   output logic [mlpd_pkg::BYTE_W-1:0]             rsp_payload_byte,
   output logic                                    rsp_last,
   output logic                                    rsp_length_error,
   // configuration
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [mlpd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [mlpd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mlpd_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                    csr_pready
);
   import mlpd_pkg::*;

   logic [WORD_W-1:0] xor_key_ff, xor_key_in;

   logic              in_accept;
   logic              res_valid;
   mlpd_result_type   res_item;

   logic              out_valid_ff, out_valid_in;
   mlpd_result_type   out_item_ff,  out_item_in;
   logic              skid_valid_ff, skid_valid_in;
   mlpd_result_type   skid_item_ff,  skid_item_in;
   logic              out_take;

   // configuration port, zero wait state
   assign csr_pready = 1'b1;

   always_comb begin
      xor_key_in = xor_key_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == CSR_XOR_KEY_ADDR)) begin
         xor_key_in = csr_pwdata;
      end
   end

   always_comb begin
      unique case (csr_paddr)
         CSR_XOR_KEY_ADDR: csr_prdata = xor_key_ff;
         default:          csr_prdata = '0;
      endcase
   end

   // input side: stall only when the skid register is occupied
   assign req_ready = !skid_valid_ff;
   assign in_accept = req_valid && req_ready;

   mlpd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .in_byte   (req_data_byte),
      .xor_key   (xor_key_ff),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   // output register with skid stage behind it
   assign out_take = out_valid_ff && rsp_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_item_in   = out_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (skid_valid_ff) begin
         // no new item can arrive here, just drain the skid entry
         if (out_take) begin
            out_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_item_in  = res_item;
         end else begin
            skid_valid_in = 1'b1;
            skid_item_in  = res_item;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xor_key_ff    <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         xor_key_ff    <= xor_key_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_item_type    = out_item_ff.item_type;
   assign rsp_pack_id      = out_item_ff.pack_id;
   assign rsp_frame_length = out_item_ff.frame_length;
   assign rsp_payload_byte = out_item_ff.payload_byte;
   assign rsp_last         = out_item_ff.last;
   assign rsp_length_error = out_item_ff.length_error;

endmodule

`default_nettype wire

/* design/mlpd_checker.sv */
// port-level checks for the masked length-prefix deframer, bound to the top level
// depends on mlpd_pkg and masked_length_prefix_deframer
`default_nettype none

module mlpd_port_checks (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_ready,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   input  wire logic                               rsp_item_type,
   input  wire logic [mlpd_pkg::WORD_W-1:0]        rsp_pack_id,
   input  wire logic [mlpd_pkg::LENGTH_W-1:0]      rsp_frame_length,
   input  wire logic [mlpd_pkg::BYTE_W-1:0]        rsp_payload_byte,
   input  wire logic                               rsp_last,
   input  wire logic                               rsp_length_error
);
   import mlpd_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pack_id)
         && $stable(rsp_payload_byte) && $stable(rsp_last)))
      else $error("stalled result changed");

   // an errored header closes the frame with no length
   a_err_header: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_length_error) |->
         (rsp_item_type == ITEM_HEADER && rsp_last && rsp_frame_length == '0))
      else $error("length error result malformed");

   // payload results carry no length or error
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item_type == ITEM_PAYLOAD) |->
         (!rsp_length_error && rsp_frame_length == '0))
      else $error("payload result carries header fields");

   // a header that opens a payload has a nonzero length and no payload byte
   a_open_header: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item_type == ITEM_HEADER && !rsp_last) |->
         (rsp_frame_length != '0 && rsp_payload_byte == '0))
      else $error("open header without length");

   // nothing pending in the first cycle out of reset
   a_reset_idle: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> (!rsp_valid && req_ready))
      else $error("result or stall present after reset");

endmodule

bind masked_length_prefix_deframer mlpd_port_checks u_mlpd_port_checks (.*);

`default_nettype wire
